// ----- sv/rwt_pkg.sv -----
// Shared types, command codes and helpers for the retransmit window table.
`timescale 1ns / 1ps

package rwt_pkg;

	localparam int SLOTS_DEF  = 8;
	localparam int WINDOW_DEF = 15;
	localparam int QDEPTH     = 2;

	localparam logic [7:0] SEQ_INIT = 8'h80;
	localparam logic [7:0] SEQ_ONE  = 8'h01;

	// command codes on the input word
	localparam logic [3:0] CMD_ALLOC   = 4'd0;
	localparam logic [3:0] CMD_SENT    = 4'd1;
	localparam logic [3:0] CMD_RESEND  = 4'd2;
	localparam logic [3:0] CMD_RESALL  = 4'd3;
	localparam logic [3:0] CMD_TAKE    = 4'd4;
	localparam logic [3:0] CMD_FIND    = 4'd5;
	localparam logic [3:0] CMD_NEXT    = 4'd6;
	localparam logic [3:0] CMD_REMOVE  = 4'd7;
	localparam logic [3:0] CMD_START   = 4'd8;

	typedef enum logic [3:0] {
		OP_ALLOC, OP_SENT, OP_RESEND, OP_RESALL, OP_TAKE,
		OP_FIND, OP_NEXT, OP_REMOVE, OP_START, OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] sn;
	} qword_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_PREC, ST_EARL, ST_PICK, ST_DONE
	} state_t;

	// next sequence number: 1..127 wraps to 1, 255 rolls to 0
	function automatic logic [7:0] succ(input logic [7:0] n);
		logic [7:0] x;
		x = n + 8'd1;
		succ = x[7] ? SEQ_ONE : x;
	endfunction

endpackage

// ----- sv/rwt_queue.sv -----
// Short command queue between the decode front and the execution engine.
`timescale 1ns / 1ps

module rwt_queue
	import rwt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qword_t wdata,
	input  logic   pop,
	output qword_t rdata,
	output qstat_t stat
);

	localparam int PW = $clog2(QDEPTH);

	qword_t          mem_q [QDEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;

	assign stat.full  = (cnt_q == (PW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_q];

	// store incoming words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QDEPTH-1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QDEPTH-1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

// ----- sv/rwt_engine.sv -----
// Execution engine: slot table, window scans and the result register.
`timescale 1ns / 1ps

module rwt_engine
	import rwt_pkg::*;
#(
	parameter int SLOTS  = SLOTS_DEF,
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qword_t      qdata,
	input  qstat_t      qstat,
	output logic        qpop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // found, slot[2:0], seq_out[7:0], zero pad
);

	localparam int IW = $clog2(SLOTS);
	localparam int SW = $clog2(WINDOW + 1);

	state_t            state_q, state_d;
	logic [SLOTS-1:0]  live_q, pend_q;
	logic [7:0]        seq_q [SLOTS];
	logic [7:0]        run_q [SLOTS];
	logic [7:0]        earliest_q, n_q, cur_sn_q;
	logic              started_q;
	op_t               cur_op_q;
	logic [SW-1:0]     step_q;
	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic              out_found_q;
	logic [2:0]        out_slot_q;
	logic [7:0]        out_seq_q;
	logic              out_valid_q;

	logic [SLOTS-1:0]  eqs, eqn, free_v, take_v, pick_v;
	logic              last_step, enter_earl, out_go;
	logic [7:0]        scan_start;

	function automatic logic [IW-1:0] first_idx(input logic [SLOTS-1:0] v);
		logic got;
		first_idx = '0;
		got = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (v[i] && !got) begin
				first_idx = IW'(i);
				got = 1'b1;
			end
		end
	endfunction

	// per-slot number compares
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			eqs[i] = live_q[i] && (seq_q[i] == cur_sn_q);
			eqn[i] = live_q[i] && (seq_q[i] == n_q);
		end
	end

	assign free_v     = ~live_q;
	assign take_v     = live_q & pend_q;
	assign pick_v     = eqn & pend_q;
	assign last_step  = (step_q == SW'(WINDOW - 1));
	assign scan_start = started_q ? earliest_q : SEQ_INIT;
	assign out_go     = !out_valid_q || m_axis_tready;
	assign enter_earl = ((state_q == ST_EXEC) && (cur_op_q == OP_NEXT)) ||
		((state_q == ST_PREC) && last_step);

	// next state
	always_comb begin
		state_d = state_q;
		qpop    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!qstat.empty) begin
					qpop    = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cur_op_q == OP_NEXT) begin
					state_d = ST_EARL;
				end else if ((cur_op_q == OP_REMOVE) && (|eqs)) begin
					state_d = ST_PREC;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_PREC: begin
				if (last_step) state_d = ST_EARL;
			end
			ST_EARL: begin
				if ((|eqn) || last_step) begin
					state_d = (cur_op_q == OP_NEXT) ? ST_PICK : ST_DONE;
				end
			end
			ST_PICK: begin
				if ((|pick_v) || last_step) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			live_q      <= '0;
			pend_q      <= '0;
			earliest_q  <= SEQ_INIT;
			started_q   <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC) begin
				case (cur_op_q)
					OP_ALLOC: begin
						if (|free_v) begin
							live_q[first_idx(free_v)] <= 1'b1;
							pend_q[first_idx(free_v)] <= 1'b1;
						end
					end
					OP_SENT:   pend_q <= pend_q & ~eqs;
					OP_RESEND: pend_q <= pend_q | eqs;
					OP_RESALL: pend_q <= pend_q | live_q;
					OP_TAKE: begin
						if (|take_v) pend_q[first_idx(take_v)] <= 1'b0;
					end
					OP_REMOVE: begin
						live_q <= live_q & ~eqs;
						pend_q <= pend_q & ~eqs;
					end
					OP_START: begin
						started_q  <= 1'b1;
						earliest_q <= SEQ_ONE;
					end
					default: ;
				endcase
			end
			// mark live slots whose number lies within the window before the removed number
			if (state_q == ST_PREC) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (live_q[i] && (succ(run_q[i]) == cur_sn_q)) pend_q[i] <= 1'b1;
				end
			end
			if (enter_earl && !started_q) earliest_q <= SEQ_INIT;
			if ((state_q == ST_EARL) && (|eqn)) earliest_q <= n_q;
			// window step counter
			if (enter_earl || (state_q == ST_EXEC) ||
				((state_q == ST_EARL) && (state_d == ST_PICK))) begin
				step_q <= '0;
			end else if ((state_q == ST_PREC) || (state_q == ST_EARL) ||
				(state_q == ST_PICK)) begin
				step_q <= step_q + SW'(1);
			end
			// result register handshake
			if ((state_q == ST_DONE) && out_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_op_q <= qdata.op;
				cur_sn_q <= qdata.sn;
				hit_q    <= 1'b0;
			end
			ST_EXEC: begin
				case (cur_op_q)
					OP_ALLOC: begin
						if (|free_v) begin
							seq_q[first_idx(free_v)] <= cur_sn_q;
							hit_q     <= 1'b1;
							hit_idx_q <= first_idx(free_v);
						end
					end
					OP_TAKE: begin
						hit_q     <= |take_v;
						hit_idx_q <= first_idx(take_v);
					end
					OP_FIND, OP_REMOVE: begin
						hit_q     <= |eqs;
						hit_idx_q <= first_idx(eqs);
					end
					default: ;
				endcase
				for (int i = 0; i < SLOTS; i++) run_q[i] <= seq_q[i];
				n_q <= scan_start;
			end
			ST_PREC: begin
				for (int i = 0; i < SLOTS; i++) run_q[i] <= succ(run_q[i]);
				n_q <= scan_start;
			end
			ST_EARL: begin
				if (|eqn) begin
					n_q <= n_q;
				end else if (last_step) begin
					n_q <= earliest_q;
				end else begin
					n_q <= succ(n_q);
				end
			end
			ST_PICK: begin
				if (|pick_v) begin
					hit_q     <= 1'b1;
					hit_idx_q <= first_idx(pick_v);
				end
				n_q <= succ(n_q);
			end
			ST_DONE: begin
				if (out_go) begin
					out_found_q <= hit_q;
					out_slot_q  <= hit_q ? 3'(hit_idx_q) : 3'd0;
					out_seq_q   <= hit_q ? seq_q[hit_idx_q] : 8'd0;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_seq_q, out_slot_q, out_found_q};

endmodule

// ----- sv/retransmit_window_table.sv -----
// Top level: command decode front, queue and execution engine.
`timescale 1ns / 1ps

// Sender-side retransmit table for a sequence-numbered link. Each input word
// carries a command and a sequence number and gives exactly one result word.
// Words enter a two-entry queue; the engine then takes one command at a
// time. Simple commands pass through the dequeue, execute and result states
// in the engine. "next" adds the one-number-per-cycle window scan, and
// "remove" (on a hit) adds the per-slot stepping of the before-removed check
// and then the window scan. No clearing pass is needed.
module retransmit_window_table
	import rwt_pkg::*;
#(
	parameter int SLOTS  = SLOTS_DEF,
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // cmd[3:0], seq_number[7:0], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // found, slot[2:0], seq_out[7:0], zero pad
);

	qword_t wword, qdata;
	qstat_t qstat;
	logic   push, qpop;

	// classify the incoming command
	always_comb begin
		wword.sn = s_axis_tdata[11:4];
		unique case (s_axis_tdata[3:0])
			CMD_ALLOC:  wword.op = OP_ALLOC;
			CMD_SENT:   wword.op = OP_SENT;
			CMD_RESEND: wword.op = OP_RESEND;
			CMD_RESALL: wword.op = OP_RESALL;
			CMD_TAKE:   wword.op = OP_TAKE;
			CMD_FIND:   wword.op = OP_FIND;
			CMD_NEXT:   wword.op = OP_NEXT;
			CMD_REMOVE: wword.op = OP_REMOVE;
			CMD_START:  wword.op = OP_START;
			default:    wword.op = OP_NOP;
		endcase
	end

	assign s_axis_tready = !qstat.full;
	assign push          = s_axis_tvalid && s_axis_tready;

	rwt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wword),
		.pop    (qpop),
		.rdata  (qdata),
		.stat   (qstat)
	);

	rwt_engine #(
		.SLOTS  (SLOTS),
		.WINDOW (WINDOW)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.qdata         (qdata),
		.qstat         (qstat),
		.qpop          (qpop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// an empty result carries zero slot and number
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[15:1] == 15'd0))
		else $error("miss result with nonzero fields");

	// a full queue blocks the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !s_axis_tready)
		else $error("input accepted while queue full");

	// an accepted word lands in the queue
	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && qstat.empty) |=> !qstat.empty)
		else $error("accepted word lost");

endmodule

// ----- verif/rwt_checker.sv -----
// Checker: predicts table results from accepted command words and compares them.
`timescale 1ns / 1ps

module rwt_checker
	import rwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	output int          fail_count,
	output int          pending_results,
	output int          result_count
);

	localparam int NSLOT = 8;
	localparam int WIN   = 15;

	logic       tbl_live [NSLOT];
	logic       tbl_pend [NSLOT];
	logic [7:0] tbl_seq  [NSLOT];
	logic [7:0] earliest;
	logic       is_started;

	logic [11:0] result_q [$];

	function automatic logic [7:0] seq_after(input logic [7:0] n);
		logic [7:0] x;
		x = n + 8'd1;
		return (x >= 8'd128) ? 8'd1 : x;
	endfunction

	// move earliest to the first live number in the window
	task automatic refresh_earliest();
		logic [7:0] n;
		logic hit;
		hit = 1'b0;
		if (!is_started)
			earliest = SEQ_INIT;
		n = earliest;
		for (int j = 0; j < WIN; j++) begin
			for (int i = 0; i < NSLOT; i++)
				if (!hit && tbl_live[i] && tbl_seq[i] == n) begin
					earliest = n;
					hit = 1'b1;
				end
			n = seq_after(n);
		end
	endtask

	function automatic logic is_before(input logic [7:0] p, input logic [7:0] target);
		for (int k = 0; k < WIN; k++) begin
			p = seq_after(p);
			if (p == target)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// apply one command and return {seq_out, slot, found}
	task automatic table_step(input logic [3:0] cmd, input logic [7:0] sn,
			output logic [11:0] res);
		int hit;
		logic [7:0] n;
		hit = -1;
		case (cmd)
			CMD_ALLOC: begin
				for (int i = 0; i < NSLOT; i++)
					if (hit < 0 && !tbl_live[i]) begin
						tbl_live[i] = 1'b1;
						tbl_pend[i] = 1'b1;
						tbl_seq[i]  = sn;
						hit = i;
					end
			end
			CMD_SENT: begin
				for (int i = 0; i < NSLOT; i++)
					if (tbl_live[i] && tbl_seq[i] == sn)
						tbl_pend[i] = 1'b0;
			end
			CMD_RESEND: begin
				for (int i = 0; i < NSLOT; i++)
					if (tbl_live[i] && tbl_seq[i] == sn)
						tbl_pend[i] = 1'b1;
			end
			CMD_RESALL: begin
				for (int i = 0; i < NSLOT; i++)
					if (tbl_live[i])
						tbl_pend[i] = 1'b1;
			end
			CMD_TAKE: begin
				for (int i = 0; i < NSLOT; i++)
					if (hit < 0 && tbl_live[i] && tbl_pend[i]) begin
						tbl_pend[i] = 1'b0;
						hit = i;
					end
			end
			CMD_FIND: begin
				for (int i = 0; i < NSLOT; i++)
					if (hit < 0 && tbl_live[i] && tbl_seq[i] == sn)
						hit = i;
			end
			CMD_NEXT: begin
				refresh_earliest();
				n = earliest;
				for (int j = 0; j < WIN; j++) begin
					for (int i = 0; i < NSLOT; i++)
						if (hit < 0 && tbl_live[i] && tbl_pend[i] && tbl_seq[i] == n)
							hit = i;
					n = seq_after(n);
				end
			end
			CMD_REMOVE: begin
				for (int i = 0; i < NSLOT; i++)
					if (tbl_live[i] && tbl_seq[i] == sn) begin
						tbl_live[i] = 1'b0;
						tbl_pend[i] = 1'b0;
						if (hit < 0)
							hit = i;
					end
				if (hit >= 0) begin
					for (int i = 0; i < NSLOT; i++)
						if (tbl_live[i] && is_before(tbl_seq[i], sn))
							tbl_pend[i] = 1'b1;
					refresh_earliest();
				end
			end
			CMD_START: begin
				is_started = 1'b1;
				earliest   = SEQ_ONE;
			end
			default: ;
		endcase
		if (hit >= 0)
			res = {tbl_seq[hit], hit[2:0], 1'b1};
		else
			res = '0;
	endtask

	assign pending_results = result_q.size();

	// predict on accepted command words, compare accepted result words
	always @(posedge clk or negedge arst_n) begin
		logic [11:0] res;
		logic [11:0] want;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				tbl_live[i] = 1'b0;
				tbl_pend[i] = 1'b0;
				tbl_seq[i]  = '0;
			end
			earliest     = SEQ_INIT;
			is_started   = 1'b0;
			fail_count   = 0;
			result_count = 0;
			result_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				result_count++;
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", m_axis_tdata);
				end else begin
					want = result_q.pop_front();
					if (m_axis_tdata[0] !== want[0] || m_axis_tdata[3:1] !== want[3:1]
							|| m_axis_tdata[11:4] !== want[11:4]
							|| m_axis_tdata[15:12] !== 4'd0) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: found %b/%b slot %0d/%0d seq %0d/%0d (exp/act)",
								want[0], m_axis_tdata[0], want[3:1], m_axis_tdata[3:1],
								want[11:4], m_axis_tdata[11:4]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				table_step(s_axis_tdata[3:0], s_axis_tdata[11:4], res);
				result_q.push_back(res);
			end
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Testbench top: drives command words into the table and gives the verdict.
`timescale 1ns / 1ps

module testbench;
	import rwt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	int fail_count, pending_results, result_count;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;
	int sent_words = 0;
	logic [7:0] seq_ctr = 8'd1;

	always #1 clk = ~clk;

	retransmit_window_table u_top (.*);

	rwt_checker u_chk (.*);

	// receiver stalls at the falling edge
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	// guard against a hung handshake
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** retransmit_window_table: FAILED **");
			$finish;
		end
	end

	// idle for a while, then present one word and hold it until accepted
	task automatic send_word(input logic [3:0] cmd, input logic [7:0] sn);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 16'($urandom) & 16'h0fff;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, sn, cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		sent_words++;
	endtask

	// drop valid and wait until every expected result has come
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 16'($urandom) & 16'h0fff;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// mostly a well-formed link flow on recent numbers, some noise
	task automatic random_word();
		int r;
		logic [7:0] sn;
		r = $urandom_range(99);
		sn = seq_ctr - 8'($urandom_range(10));
		if (sn == 0 || sn >= 8'd128)
			sn = 8'($urandom_range(127, 1));
		if (r < 22) begin
			send_word(CMD_ALLOC, seq_ctr);
			seq_ctr = (seq_ctr >= 8'd127) ? 8'd1 : seq_ctr + 8'd1;
		end else if (r < 30) send_word(CMD_SENT, sn);
		else if (r < 36) send_word(CMD_RESEND, sn);
		else if (r < 39) send_word(CMD_RESALL, sn);
		else if (r < 49) send_word(CMD_TAKE, sn);
		else if (r < 56) send_word(CMD_FIND, sn);
		else if (r < 72) send_word(CMD_NEXT, sn);
		else if (r < 90) send_word(CMD_REMOVE, sn);
		else if (r < 92) send_word(CMD_START, sn);
		else if (r < 94) send_word(4'($urandom_range(15, 9)), 8'($urandom));
		else send_word(4'($urandom_range(8)), 8'($urandom));
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: init packet before start, full table, wrap, odd numbers
		send_word(CMD_NEXT, 8'd0);
		send_word(CMD_ALLOC, SEQ_INIT);
		send_word(CMD_NEXT, 8'd0);
		send_word(CMD_FIND, SEQ_INIT);
		send_word(CMD_REMOVE, SEQ_INIT);
		send_word(CMD_START, 8'd0);
		for (int i = 0; i < 9; i++)
			send_word(CMD_ALLOC, 8'(122 + i));
		send_word(CMD_SENT, 8'd123);
		send_word(CMD_RESEND, 8'd123);
		send_word(CMD_TAKE, 8'd0);
		send_word(CMD_RESALL, 8'd0);
		send_word(CMD_REMOVE, 8'd2);
		send_word(CMD_NEXT, 8'd0);
		send_word(CMD_REMOVE, 8'd255);
		send_word(4'hf, 8'hff);
		send_word(CMD_FIND, 8'd0);
		drain();

		// random phases over the idling mixes
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin send_idle_pct = 83; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 83; end
				3: begin send_idle_pct = 14; stall_pct = 14; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			for (int k = 0; k < 260; k++) begin
				random_word();
				if (k == 130)
					drain();
			end
		end

		drain();
		repeat (80) @(negedge clk);
		$display("sent %0d command words, checked %0d result words", sent_words, result_count);
		$display("covered all commands, full table, wrap and window resends");
		if (fail_count == 0 && pending_results == 0)
			$display("** retransmit_window_table: PASSED **");
		else
			$display("** retransmit_window_table: FAILED **");
		$finish;
	end

endmodule
